>>> rtl/sle_pkg.sv
// Shared types and constants for the sorted list engine.
package sle_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

>>> rtl/sle_if.sv
// Request and result channel interfaces of the sorted list engine.
interface sle_in_if
    import sle_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic        [KIND_W-1:0]   kind;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sle_out_if
    import sle_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value_res;
    logic        [STATUS_W-1:0] status;
    logic        [COUNT_W-1:0]  count;
    logic                       last;

    modport source (output valid, output value_res, output status, output count,
                    output last, input ready);
    modport sink   (input valid, input value_res, input status, input count,
                    input last, output ready);
endinterface

>>> rtl/sle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sle_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/sle_cmp.sv
// Shared signed comparator: stored entry against the request operand.
module sle_cmp
    import sle_pkg::*;
(
    input  logic signed [VALUE_W-1:0] i_entry,
    input  logic signed [VALUE_W-1:0] i_operand,
    output t_cmp                      o_cmp
);
    always_comb begin
        o_cmp.lt = (i_entry < i_operand);
        o_cmp.eq = (i_entry == i_operand);
    end
endmodule

>>> rtl/sorted_list_engine_unit.sv
// Sorted list engine: holds up to CAPACITY signed 32-bit values in ascending
// order in a RAM and walks it one entry at a time through a shared comparator.
// Every entry visited takes a RAM read, then a compare and write back.
// Insert walks back from the tail shifting entries not less than the value up,
// delete and search walk forward from the head, delete then shifts the tail down.
// A read emits the entries in order from the head and waits while the result
// side stalls. A full insert and a read of an empty list are answered without
// a walk. One request is in work at a time; the next is taken once the final
// result of the current one is in the output register.
module sorted_list_engine_unit
    import sle_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sle_in_if.sink    i_req,
    sle_out_if.source o_res
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [KIND_W-1:0]          r_op, n_op;
    logic signed [VALUE_W-1:0]  r_val, n_val;
    logic [OW-1:0]              r_idx, n_idx;
    logic [OW-1:0]              r_occ, n_occ;
    logic                       r_found, n_found;
    logic [STATUS_W-1:0]        r_status, n_status;

    logic                       r_o_valid, n_o_valid;
    logic signed [VALUE_W-1:0]  r_o_value, n_o_value;
    logic [STATUS_W-1:0]        r_o_status, n_o_status;
    logic [COUNT_W-1:0]         r_o_count, n_o_count;
    logic                       r_o_last, n_o_last;

    logic                       we, re;
    logic [AW-1:0]              waddr, raddr;
    logic signed [VALUE_W-1:0]  wdata, rdata;
    t_cmp                       cmp;
    logic                       out_free;
    logic [OW-1:0]              idx_inc, idx_dec;

    sle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sle_cmp u_cmp (
        .i_entry   (rdata),
        .i_operand (r_val),
        .o_cmp     (cmp)
    );

    assign out_free = !r_o_valid || o_res.ready;
    assign idx_inc  = r_idx + OW'(1);
    assign idx_dec  = r_idx - OW'(1);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_val      = r_val;
        n_idx      = r_idx;
        n_occ      = r_occ;
        n_found    = r_found;
        n_status   = r_status;
        n_o_valid  = r_o_valid && !o_res.ready;
        n_o_value  = r_o_value;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        n_o_last   = r_o_last;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = r_idx[AW-1:0];
        wdata      = rdata;
        raddr      = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.kind;
                    n_val   = i_req.value;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_RD;
                    if (i_req.kind == KIND_INSERT) begin
                        if (r_occ == OW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_idx = r_occ;
                        end
                    end
                end
            end
            S_RD: begin
                case (r_op)
                    KIND_INSERT: begin
                        if (r_idx == '0) begin
                            we       = 1'b1;
                            wdata    = r_val;
                            n_occ    = r_occ + OW'(1);
                            n_status = ST_DONE;
                            n_state  = S_DONE;
                        end else begin
                            re      = 1'b1;
                            raddr   = idx_dec[AW-1:0];
                            n_state = S_EV;
                        end
                    end
                    KIND_DELETE: begin
                        if (r_found) begin
                            if (idx_inc == r_occ) begin
                                n_occ    = r_occ - OW'(1);
                                n_status = ST_DONE;
                                n_state  = S_DONE;
                            end else begin
                                re      = 1'b1;
                                raddr   = idx_inc[AW-1:0];
                                n_state = S_EV;
                            end
                        end else if (r_idx == r_occ) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            re      = 1'b1;
                            n_state = S_EV;
                        end
                    end
                    KIND_SEARCH: begin
                        if (r_idx == r_occ) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            re      = 1'b1;
                            n_state = S_EV;
                        end
                    end
                    default: begin
                        if (r_occ == '0) begin
                            n_val    = '0;
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            re      = 1'b1;
                            n_state = S_EV;
                        end
                    end
                endcase
            end
            S_EV: begin
                case (r_op)
                    KIND_INSERT: begin
                        we = 1'b1;
                        if (!cmp.lt) begin
                            n_idx   = idx_dec;
                            n_state = S_RD;
                        end else begin
                            wdata    = r_val;
                            n_occ    = r_occ + OW'(1);
                            n_status = ST_DONE;
                            n_state  = S_DONE;
                        end
                    end
                    KIND_DELETE: begin
                        if (r_found) begin
                            we      = 1'b1;
                            n_idx   = idx_inc;
                            n_state = S_RD;
                        end else if (cmp.lt) begin
                            n_idx   = idx_inc;
                            n_state = S_RD;
                        end else if (cmp.eq) begin
                            n_found = 1'b1;
                            n_state = S_RD;
                        end else begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                    end
                    KIND_SEARCH: begin
                        if (cmp.lt) begin
                            n_idx   = idx_inc;
                            n_state = S_RD;
                        end else begin
                            n_status = cmp.eq ? ST_FOUND : ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            n_o_valid  = 1'b1;
                            n_o_value  = rdata;
                            n_o_status = ST_ENTRY;
                            n_o_count  = COUNT_W'(r_occ);
                            n_o_last   = (idx_inc == r_occ);
                            if (idx_inc == r_occ) begin
                                n_state = S_IDLE;
                            end else begin
                                n_idx   = idx_inc;
                                n_state = S_RD;
                            end
                        end
                    end
                endcase
            end
            default: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_value  = r_val;
                    n_o_status = r_status;
                    n_o_count  = COUNT_W'(r_occ);
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_o_valid <= n_o_valid;
        end
        r_op       <= n_op;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_status   <= n_status;
        r_o_value  <= n_o_value;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_last   <= n_o_last;
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_o_valid;
    assign o_res.value_res = r_o_value;
    assign o_res.status    = r_o_status;
    assign o_res.count     = r_o_count;
    assign o_res.last      = r_o_last;
endmodule
